// ===== sv/slcd_pkg.sv =====
package slcd_pkg;

    // Input item: one display frame
    typedef struct packed {
        logic [13:0] speed_value;
        logic [19:0] time_seconds;
        logic        set_time_positive;
        logic        speed_blank;
        logic        time_blank;
        logic        unit_icon_blank;
        logic        colon_blank;
        logic        lid_open;
        logic        lock_icon_blank;
    } slcd_in_t;

    // Result item: eight segment bytes
    typedef struct packed {
        logic [7:0] speed_thousands_byte;
        logic [7:0] speed_hundreds_byte;
        logic [7:0] speed_tens_byte;
        logic [7:0] speed_units_byte;
        logic [7:0] minute_tens_byte;
        logic [7:0] minute_units_byte;
        logic [7:0] second_tens_byte;
        logic [7:0] second_units_byte;
    } slcd_out_t;

    // Display control flags that travel beside the digit lanes
    typedef struct packed {
        logic show_thousands;
        logic show_hundreds;
        logic show_tens;
        logic set_time_positive;
        logic speed_blank;
        logic time_blank;
        logic unit_icon_blank;
        logic colon_blank;
        logic lid_open;
        logic lock_icon_blank;
    } slcd_flags_t;

    // Four BCD digits, index 3 is the most significant
    typedef logic [3:0][3:0] slcd_bcd4_t;

    typedef struct packed {
        logic [10:0] quo;
        logic [3:0]  rem;
    } slcd_div10_t;

    localparam logic [13:0] SPEED_MAX        = 14'd9999;
    localparam logic [13:0] SPEED_SHOW_THOU  = 14'd999;
    localparam logic [13:0] SPEED_SHOW_HUND  = 14'd99;
    localparam logic [13:0] SPEED_SHOW_TENS  = 14'd9;

    // Reciprocal of ten, exact for every 14-bit value
    localparam logic [13:0] DIV10_MUL        = 14'd13108;
    localparam int          DIV10_SHIFT      = 17;
    // Reciprocal of sixty, low by at most one for any 20-bit value
    localparam logic [20:0] DIV60_MUL_WIDE   = 21'd1118481;
    localparam int          DIV60_SHIFT_WIDE = 26;
    // Reciprocal of sixty, exact for quotients below 17477
    localparam logic [14:0] DIV60_MUL_NARROW = 15'd17477;
    localparam int          DIV60_SHIFT_NARROW = 20;
    localparam logic [6:0]  SECS_PER_MIN     = 7'd60;

    localparam logic [6:0]  SEG_DASH         = 7'h08;

    // Split a 14-bit value into quotient and remainder by ten
    function automatic slcd_div10_t div10(input logic [13:0] x);
        logic [27:0] prod;
        logic [10:0] quo;
        logic [13:0] back;
        logic [13:0] diff;
        slcd_div10_t r;
        prod  = {14'd0, x} * {14'd0, DIV10_MUL};
        quo   = prod[DIV10_SHIFT +: 11];
        back  = {quo, 3'b000} + {2'b00, quo, 1'b0};
        diff  = x - back;
        r.quo = quo;
        r.rem = diff[3:0];
        return r;
    endfunction

endpackage

// ===== sv/slcd_speed_digits.sv =====
module slcd_speed_digits (
    input  logic                clk,
    input  logic [13:0]         speed,
    output slcd_pkg::slcd_bcd4_t digits
);
    import slcd_pkg::*;

    slcd_div10_t div_a;
    slcd_div10_t div_b;
    slcd_div10_t div_c;

    logic [9:0] q1_reg;
    logic [3:0] d0_a_reg;
    logic [6:0] q2_reg;
    logic [3:0] d1_b_reg;
    logic [3:0] d0_b_reg;
    slcd_bcd4_t digits_reg;

    // Peel one decimal digit per stage; the last stage gives the top two digits
    always_comb
    begin
        div_a = div10(speed);
        div_b = div10({4'b0000, q1_reg});
        div_c = div10({7'b0000000, q2_reg});
    end

    // Advance the digit lanes
    always_ff @(posedge clk)
    begin
        q1_reg     <= div_a.quo[9:0];
        d0_a_reg   <= div_a.rem;
        q2_reg     <= div_b.quo[6:0];
        d1_b_reg   <= div_b.rem;
        d0_b_reg   <= d0_a_reg;
        digits_reg <= {div_c.quo[3:0], div_c.rem, d1_b_reg, d0_b_reg};
    end

    assign digits = digits_reg;

endmodule

// ===== sv/slcd_time_digits.sv =====
module slcd_time_digits (
    input  logic                clk,
    input  logic [19:0]         secs,
    output slcd_pkg::slcd_bcd4_t digits
);
    import slcd_pkg::*;

    logic [40:0] prod_wide;
    logic [14:0] q0_reg;
    logic [19:0] secs_reg;

    logic [20:0] back_wide;
    logic [20:0] rem_wide;
    logic [14:0] q_next;
    logic [5:0]  s_next;
    logic [14:0] q_reg;
    logic [5:0]  s_reg;

    logic [29:0] prod_narrow;
    slcd_div10_t sec_div;
    logic [8:0]  hours_reg;
    logic [14:0] mins_all_reg;
    logic [3:0]  sec_tens_reg;
    logic [3:0]  sec_units_reg;

    logic [14:0] back_narrow;
    logic [14:0] mins_wide;
    slcd_div10_t min_div;

    // Estimate whole minutes by reciprocal multiply
    assign prod_wide = {21'd0, secs} * {20'd0, DIV60_MUL_WIDE};

    always_ff @(posedge clk)
    begin
        q0_reg   <= prod_wide[DIV60_SHIFT_WIDE +: 15];
        secs_reg <= secs;
    end

    // Correct the estimate and take the seconds remainder
    always_comb
    begin
        back_wide = {q0_reg, 6'b000000} - {4'b0000, q0_reg, 2'b00};
        rem_wide  = {1'b0, secs_reg} - back_wide;
        if (rem_wide[6:0] >= SECS_PER_MIN)
        begin
            q_next = q0_reg + 15'd1;
            s_next = 6'(rem_wide[6:0] - SECS_PER_MIN);
        end
        else
        begin
            q_next = q0_reg;
            s_next = rem_wide[5:0];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        s_reg <= s_next;
    end

    // Drop hours and split the seconds into digits
    always_comb
    begin
        prod_narrow = {15'd0, q_reg} * {15'd0, DIV60_MUL_NARROW};
        sec_div     = div10({8'b00000000, s_reg});
    end

    always_ff @(posedge clk)
    begin
        hours_reg     <= prod_narrow[DIV60_SHIFT_NARROW +: 9];
        mins_all_reg  <= q_reg;
        sec_tens_reg  <= sec_div.quo[3:0];
        sec_units_reg <= sec_div.rem;
    end

    // Minutes mod sixty, then minute digits
    always_comb
    begin
        back_narrow = {hours_reg, 6'b000000} - {4'b0000, hours_reg, 2'b00};
        mins_wide   = mins_all_reg - back_narrow;
        min_div     = div10({8'b00000000, mins_wide[5:0]});
    end

    assign digits = {min_div.quo[3:0], min_div.rem, sec_tens_reg, sec_units_reg};

endmodule

// ===== sv/slcd_seg_encode.sv =====
module slcd_seg_encode (
    input  slcd_pkg::slcd_bcd4_t  speed_digits,
    input  slcd_pkg::slcd_bcd4_t  time_digits,
    input  slcd_pkg::slcd_flags_t flags,
    input  logic                  unit_xg,
    output slcd_pkg::slcd_out_t   segs
);
    import slcd_pkg::*;

    // Seven-segment pattern of one decimal digit
    function automatic logic [6:0] pattern(input logic [3:0] d);
        logic [6:0] p;
        case (d)
            4'd0:    p = 7'h77;
            4'd1:    p = 7'h24;
            4'd2:    p = 7'h5D;
            4'd3:    p = 7'h6D;
            4'd4:    p = 7'h2E;
            4'd5:    p = 7'h6B;
            4'd6:    p = 7'h7B;
            4'd7:    p = 7'h25;
            4'd8:    p = 7'h7F;
            4'd9:    p = 7'h6F;
            default: p = 7'h00;
        endcase
        return p;
    endfunction

    logic [3:0][6:0] spd_pat;
    logic [3:0][6:0] tim_pat;
    logic [7:0]      icon;

    // Blank leading zeros and blinking fields; show dashes when no time is set
    always_comb
    begin
        spd_pat[3] = (!flags.speed_blank && flags.show_thousands) ?
                     pattern(speed_digits[3]) : 7'h00;
        spd_pat[2] = (!flags.speed_blank && flags.show_hundreds) ?
                     pattern(speed_digits[2]) : 7'h00;
        spd_pat[1] = (!flags.speed_blank && flags.show_tens) ?
                     pattern(speed_digits[1]) : 7'h00;
        spd_pat[0] = !flags.speed_blank ? pattern(speed_digits[0]) : 7'h00;
        for (int i = 0; i < 4; i++)
        begin
            if (flags.time_blank)
                tim_pat[i] = 7'h00;
            else if (flags.set_time_positive)
                tim_pat[i] = pattern(time_digits[i]);
            else
                tim_pat[i] = SEG_DASH;
        end
    end

    // Place the icons, index 0 is the thousands byte
    always_comb
    begin
        icon[0] = flags.lid_open && !flags.lock_icon_blank;
        icon[1] = !flags.lid_open || !flags.lock_icon_blank;
        icon[2] = !flags.lid_open;
        icon[3] = !flags.unit_icon_blank && !unit_xg;
        icon[4] = !flags.unit_icon_blank && unit_xg;
        icon[5] = !flags.colon_blank;
        icon[6] = 1'b1;
        icon[7] = 1'b0;
    end

    always_comb
    begin
        segs.speed_thousands_byte = {icon[0], spd_pat[3]};
        segs.speed_hundreds_byte  = {icon[1], spd_pat[2]};
        segs.speed_tens_byte      = {icon[2], spd_pat[1]};
        segs.speed_units_byte     = {icon[3], spd_pat[0]};
        segs.minute_tens_byte     = {icon[4], tim_pat[3]};
        segs.minute_units_byte    = {icon[5], tim_pat[2]};
        segs.second_tens_byte     = {icon[6], tim_pat[1]};
        segs.second_units_byte    = {icon[7], tim_pat[0]};
    end

endmodule

// ===== sv/segment_lcd_speed_time_encoder.sv =====
// Channel   Handshake              Payload
// -------   ---------------------  ----------------------------
// frame     start, busy            frame (slcd_in_t)
// segs      done (strobe)          segs  (slcd_out_t)
// config    cfg_valid, cfg_ready   cfg_data (speed_unit_xg)
//
// One frame is taken every cycle; busy is always low and cfg_ready always high.
// Each result passes through five register stages: input, two divide-by-sixty
// steps, the last speed digit, output.
// done is high for one cycle per result; the receiver cannot stall.
// rst_n clears the valid chain and the unit select; data registers keep no reset.
module segment_lcd_speed_time_encoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  slcd_pkg::slcd_in_t  frame,
    output logic                done,
    output slcd_pkg::slcd_out_t segs,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import slcd_pkg::*;

    logic        accept;
    logic [13:0] speed_clamp;
    slcd_flags_t flags_in;

    logic [13:0] speed_s1_reg;
    logic [19:0] secs_s1_reg;
    slcd_flags_t flags_s1_reg;
    slcd_flags_t flags_s2_reg;
    slcd_flags_t flags_s3_reg;
    slcd_flags_t flags_s4_reg;
    logic [3:0]  valid_reg;
    logic [3:0]  valid_next;
    logic        done_reg;
    slcd_out_t   segs_reg;
    logic        unit_xg_reg;
    logic        unit_xg_next;

    slcd_bcd4_t  speed_digits;
    slcd_bcd4_t  time_digits;
    slcd_out_t   segs_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Clamp speed and decide leading-zero blanking
    always_comb
    begin
        speed_clamp = (frame.speed_value > SPEED_MAX) ? SPEED_MAX : frame.speed_value;
        flags_in.show_thousands    = speed_clamp > SPEED_SHOW_THOU;
        flags_in.show_hundreds     = speed_clamp > SPEED_SHOW_HUND;
        flags_in.show_tens         = speed_clamp > SPEED_SHOW_TENS;
        flags_in.set_time_positive = frame.set_time_positive;
        flags_in.speed_blank       = frame.speed_blank;
        flags_in.time_blank        = frame.time_blank;
        flags_in.unit_icon_blank   = frame.unit_icon_blank;
        flags_in.colon_blank       = frame.colon_blank;
        flags_in.lid_open          = frame.lid_open;
        flags_in.lock_icon_blank   = frame.lock_icon_blank;
    end

    // Capture the item and carry flags beside the digit lanes
    always_ff @(posedge clk)
    begin
        speed_s1_reg <= speed_clamp;
        secs_s1_reg  <= frame.time_seconds;
        flags_s1_reg <= flags_in;
        flags_s2_reg <= flags_s1_reg;
        flags_s3_reg <= flags_s2_reg;
        flags_s4_reg <= flags_s3_reg;
        segs_reg     <= segs_next;
    end

    // Shift the valid bits along the pipeline
    assign valid_next = {valid_reg[2:0], accept};

    assign unit_xg_next = (cfg_valid && cfg_ready) ? cfg_data : unit_xg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            done_reg    <= 1'b0;
            unit_xg_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            done_reg    <= valid_reg[3];
            unit_xg_reg <= unit_xg_next;
        end
    end

    slcd_speed_digits u_speed (
        .clk    (clk),
        .speed  (speed_s1_reg),
        .digits (speed_digits)
    );

    slcd_time_digits u_time (
        .clk    (clk),
        .secs   (secs_s1_reg),
        .digits (time_digits)
    );

    slcd_seg_encode u_encode (
        .speed_digits (speed_digits),
        .time_digits  (time_digits),
        .flags        (flags_s4_reg),
        .unit_xg      (unit_xg_reg),
        .segs         (segs_next)
    );

    assign done = done_reg;
    assign segs = segs_reg;

endmodule

// ===== sv/slcd_checker.sv =====
module slcd_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                done,
    input  slcd_pkg::slcd_out_t segs
);
    import slcd_pkg::*;

    // Every accepted item gives a result with done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##5 done)
        else $error("result missing after accepted item");

    // No result without an earlier accepted item
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result without accepted item");

    // Seconds icon always set, last byte icon always clear
    a_fixed_icons: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> segs.second_tens_byte[7] && !segs.second_units_byte[7])
        else $error("fixed icon bits wrong");

    // Only one unit icon at a time
    a_unit_icons: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(segs.speed_units_byte[7] && segs.minute_tens_byte[7]))
        else $error("both unit icons set");

    // Lid-closed and lock icons are exclusive
    a_lid_lock: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(segs.speed_tens_byte[7] && segs.speed_thousands_byte[7]))
        else $error("lid and lock icons both set");

endmodule

bind segment_lcd_speed_time_encoder slcd_checker u_slcd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .segs  (segs)
);

// ===== bench/slcd_segs_checker.sv =====
`timescale 1ns / 1ps

module slcd_segs_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  slcd_pkg::slcd_in_t  frame,
    input  logic                done,
    input  slcd_pkg::slcd_out_t segs,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_data,
    output int                  mismatches,
    output int                  pending
);

    localparam int unsigned SPEED_CLAMP     = 9999;
    localparam int unsigned SECONDS_PER_HR  = 3600;
    localparam int unsigned SECONDS_PER_MIN = 60;
    localparam logic [7:0]  DASH_SEGS       = 8'h08;
    localparam logic [7:0]  ICON_MASK       = 8'h80;
    localparam int          REPORT_LIMIT    = 10;

    slcd_pkg::slcd_out_t expected_segs[$];
    logic                unit_is_xg;
    int                  error_count;

    // Seven-segment pattern of one decimal digit, bit 7 clear
    function automatic logic [7:0] digit_segs(input int unsigned d);
        case (d)
            0:       return 8'h77;
            1:       return 8'h24;
            2:       return 8'h5D;
            3:       return 8'h6D;
            4:       return 8'h2E;
            5:       return 8'h6B;
            6:       return 8'h7B;
            7:       return 8'h25;
            8:       return 8'h7F;
            default: return 8'h6F;
        endcase
    endfunction

    // Encode one display frame into the eight segment bytes
    function automatic slcd_pkg::slcd_out_t encode_frame(input slcd_pkg::slcd_in_t f,
                                                         input logic xg);
        int unsigned         spd;
        int unsigned         secs;
        int unsigned         mins;
        int unsigned         sec_rem;
        slcd_pkg::slcd_out_t r;
        r    = '0;
        spd  = 32'(f.speed_value);
        secs = 32'(f.time_seconds);
        if (spd > SPEED_CLAMP)
            spd = SPEED_CLAMP;

        // speed digits, leading zeros blank
        if (!f.speed_blank)
        begin
            if (spd > 999)
                r.speed_thousands_byte = digit_segs((spd / 1000) % 10);
            if (spd > 99)
                r.speed_hundreds_byte = digit_segs((spd / 100) % 10);
            if (spd > 9)
                r.speed_tens_byte = digit_segs((spd / 10) % 10);
            r.speed_units_byte = digit_segs(spd % 10);
        end

        // time digits: drop hours, or dashes when no time is set
        if (!f.time_blank)
        begin
            if (f.set_time_positive)
            begin
                mins    = (secs % SECONDS_PER_HR) / SECONDS_PER_MIN;
                sec_rem = secs % SECONDS_PER_MIN;
                r.minute_tens_byte  = digit_segs(mins / 10);
                r.minute_units_byte = digit_segs(mins % 10);
                r.second_tens_byte  = digit_segs(sec_rem / 10);
                r.second_units_byte = digit_segs(sec_rem % 10);
            end
            else
            begin
                r.minute_tens_byte  = DASH_SEGS;
                r.minute_units_byte = DASH_SEGS;
                r.second_tens_byte  = DASH_SEGS;
                r.second_units_byte = DASH_SEGS;
            end
        end

        // icons
        if (!f.unit_icon_blank)
        begin
            if (xg)
                r.minute_tens_byte = r.minute_tens_byte | ICON_MASK;
            else
                r.speed_units_byte = r.speed_units_byte | ICON_MASK;
        end
        if (!f.colon_blank)
            r.minute_units_byte = r.minute_units_byte | ICON_MASK;
        r.second_tens_byte = r.second_tens_byte | ICON_MASK;
        if (!f.lid_open)
        begin
            r.speed_hundreds_byte = r.speed_hundreds_byte | ICON_MASK;
            r.speed_tens_byte     = r.speed_tens_byte | ICON_MASK;
        end
        else if (!f.lock_icon_blank)
        begin
            r.speed_thousands_byte = r.speed_thousands_byte | ICON_MASK;
            r.speed_hundreds_byte  = r.speed_hundreds_byte | ICON_MASK;
        end
        return r;
    endfunction

    task automatic compare_byte(input string field, input logic [7:0] exp_val,
                                input logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%0t segs.%s mismatch: expected %02h, got %02h",
                         $realtime, field, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        slcd_pkg::slcd_out_t exp_segs;
        if (!rst_n)
        begin
            expected_segs.delete();
            unit_is_xg  = 1'b0;
            error_count = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            // check the result leaving this cycle against the oldest item
            if (done)
            begin
                if (expected_segs.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t unexpected result: segs %h", $realtime, segs);
                end
                else
                begin
                    exp_segs = expected_segs.pop_front();
                    compare_byte("speed_thousands_byte", exp_segs.speed_thousands_byte,
                                 segs.speed_thousands_byte);
                    compare_byte("speed_hundreds_byte", exp_segs.speed_hundreds_byte,
                                 segs.speed_hundreds_byte);
                    compare_byte("speed_tens_byte", exp_segs.speed_tens_byte,
                                 segs.speed_tens_byte);
                    compare_byte("speed_units_byte", exp_segs.speed_units_byte,
                                 segs.speed_units_byte);
                    compare_byte("minute_tens_byte", exp_segs.minute_tens_byte,
                                 segs.minute_tens_byte);
                    compare_byte("minute_units_byte", exp_segs.minute_units_byte,
                                 segs.minute_units_byte);
                    compare_byte("second_tens_byte", exp_segs.second_tens_byte,
                                 segs.second_tens_byte);
                    compare_byte("second_units_byte", exp_segs.second_units_byte,
                                 segs.second_units_byte);
                end
            end

            // predict each accepted item with the unit select in force now
            if (start && !busy)
                expected_segs.push_back(encode_frame(frame, unit_is_xg));

            // track the unit select register
            if (cfg_valid && cfg_ready)
                unit_is_xg = cfg_data;

            mismatches <= error_count;
            pending    <= expected_segs.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int ITEMS_PER_PASS = 238;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    slcd_pkg::slcd_in_t  frame;
    logic                done;
    slcd_pkg::slcd_out_t segs;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_data;

    int mismatches;
    int pending;
    int cycle_count;
    int idle_pct;

    segment_lcd_speed_time_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .frame     (frame),
        .done      (done),
        .segs      (segs),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    slcd_segs_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .frame      (frame),
        .done       (done),
        .segs       (segs),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("segment_lcd_speed_time_encoder verification failed");
            $finish;
        end
    end

    // flags: set_time_positive, speed_blank, time_blank, unit_icon_blank,
    // colon_blank, lid_open, lock_icon_blank
    function automatic slcd_pkg::slcd_in_t make_frame(input logic [13:0] spd,
                                                      input logic [19:0] secs,
                                                      input logic [6:0]  flags);
        slcd_pkg::slcd_in_t f;
        f.speed_value       = spd;
        f.time_seconds      = secs;
        f.set_time_positive = flags[6];
        f.speed_blank       = flags[5];
        f.time_blank        = flags[4];
        f.unit_icon_blank   = flags[3];
        f.colon_blank       = flags[2];
        f.lid_open          = flags[1];
        f.lock_icon_blank   = flags[0];
        return f;
    endfunction

    // Random frame: spread speed over every digit count, some above range
    function automatic slcd_pkg::slcd_in_t random_frame();
        logic [13:0] spd;
        logic [19:0] secs;
        logic [6:0]  flags;
        case ($urandom_range(3))
            0:       spd = 14'($urandom_range(9));
            1:       spd = 14'($urandom_range(999));
            2:       spd = 14'($urandom_range(9999));
            default: spd = 14'($urandom_range(16383));
        endcase
        case ($urandom_range(3))
            0:       secs = 20'($urandom_range(3599));
            1:       secs = 20'($urandom_range(59));
            default: secs = 20'($urandom_range(1048575));
        endcase
        flags[6] = ($urandom_range(99) < 80);
        flags[5] = ($urandom_range(99) < 15);
        flags[4] = ($urandom_range(99) < 15);
        flags[3] = ($urandom_range(99) < 25);
        flags[2] = ($urandom_range(99) < 40);
        flags[1] = ($urandom_range(99) < 50);
        flags[0] = ($urandom_range(99) < 30);
        return make_frame(spd, secs, flags);
    endfunction

    // Offer one item, idling first at the current rate; entered and left at a falling edge
    task automatic send_frame(input slcd_pkg::slcd_in_t f);
        logic [63:0] noise;
        while ($urandom_range(99) < idle_pct)
        begin
            noise  = {$urandom, $urandom};
            start <= 1'b0;
            frame <= noise[40:0];
            @(negedge clk);
        end
        start <= 1'b1;
        frame <= f;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Write the unit select once every result is out and the pipe has drained
    task automatic write_unit_select(input logic xg);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= xg;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int idle_by_pass[4];
        idle_by_pass = '{0, 45, 0, 18};
        rst_n     = 1'b0;
        start     = 1'b0;
        frame     = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        idle_pct  = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: digit boundaries, clamp, long times, dashes, blanks, icons
        send_frame(make_frame(14'd0, 20'd0, 7'b1000000));
        send_frame(make_frame(14'd9, 20'd59, 7'b1000000));
        send_frame(make_frame(14'd10, 20'd60, 7'b1000000));
        send_frame(make_frame(14'd99, 20'd3599, 7'b1000000));
        send_frame(make_frame(14'd100, 20'd3600, 7'b1000000));
        send_frame(make_frame(14'd999, 20'd3661, 7'b1000000));
        send_frame(make_frame(14'd1000, 20'd1048575, 7'b1000000));
        send_frame(make_frame(14'd9999, 20'd35999, 7'b1000000));
        send_frame(make_frame(14'd10000, 20'd12345, 7'b1000000));
        send_frame(make_frame(14'd16383, 20'd5999, 7'b1000000));
        send_frame(make_frame(14'd1234, 20'd754, 7'b0000000));
        send_frame(make_frame(14'd5678, 20'd754, 7'b1100000));
        send_frame(make_frame(14'd5678, 20'd754, 7'b1010000));
        send_frame(make_frame(14'd42, 20'd0, 7'b0010000));
        send_frame(make_frame(14'd42, 20'd754, 7'b1001000));
        send_frame(make_frame(14'd42, 20'd754, 7'b1000100));
        send_frame(make_frame(14'd8888, 20'd754, 7'b1000010));
        send_frame(make_frame(14'd8888, 20'd754, 7'b1000011));
        send_frame(make_frame(14'd8888, 20'd754, 7'b1000001));
        send_frame(make_frame(14'd0, 20'd0, 7'b0111111));
        send_frame(make_frame(14'd16383, 20'd1048575, 7'b1111111));

        // random passes, alternating unit select and sender idle rate
        for (int pass = 0; pass < 4; pass++)
        begin
            write_unit_select((pass % 2) == 0);
            idle_pct = idle_by_pass[pass];
            if (pass == 0)
            begin
                send_frame(make_frame(14'd7, 20'd754, 7'b1000000));
                send_frame(make_frame(14'd7, 20'd754, 7'b1001000));
            end
            for (int n = 0; n < ITEMS_PER_PASS; n++)
                send_frame(random_frame());
        end

        // drain and give the verdict
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("segment_lcd_speed_time_encoder verification clean");
        else
            $display("segment_lcd_speed_time_encoder verification failed");
        $finish;
    end

endmodule
